// ----- rtl/core/rts_pkg.sv -----
`default_nettype none

package rts_pkg;

	localparam int ID_W    = 8;
	localparam int AGE_W   = 16;
	localparam int EST_W   = 24;
	localparam int STEPS_W = 16;
	localparam int ALPHA_W = 9;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	// Policy codes; the unused code dispatches like FIFO.
	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_HRRN = 2'd1;
	localparam logic [1:0] POL_SJF  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_POLICY = 1'b0;
	localparam logic CFG_ALPHA  = 1'b1;

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DISP = 2'd1,
		CMD_TICK = 2'd2,
		CMD_DONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_ENQUEUED   = 3'd0,
		STS_DISPATCHED = 3'd1,
		STS_EMPTY      = 3'd2,
		STS_FULL       = 3'd3,
		STS_REESTIM    = 3'd4,
		STS_TICKED     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENQ,
		ST_DISP,
		ST_SCAN,
		ST_PICK,
		ST_SHIFT,
		ST_TICK,
		ST_AGE,
		ST_REEST,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [AGE_W-1:0] age;
		logic [EST_W-1:0] est;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic vld;
		logic first;
	} scan_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/rts_ram.sv -----
`default_nettype none

module rts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rts_scan.sv -----
`default_nettype none

module rts_scan import rts_pkg::*; #(
	parameter int IW = 4
) (
	input  wire logic      clk,
	input  wire scan_ctl_t ctl,
	input  wire logic [1:0] policy,
	input  wire logic [IW-1:0] cand_idx,
	input  wire entry_t    cand,
	output entry_t         best,
	output logic [IW-1:0]  best_idx
);

	entry_t                   best_q;
	logic [IW-1:0]            best_idx_q;
	logic [AGE_W+EST_W-1:0]   lhs;
	logic [AGE_W+EST_W-1:0]   rhs;
	logic                     better;

	// Response ratios are compared by cross products; a candidate must beat
	// the best strictly, so ties stay with the older entry.
	always_comb begin
		lhs = cand.age * best_q.est;
		rhs = best_q.age * cand.est;
		case (policy)
			POL_HRRN: better = lhs > rhs;
			POL_SJF:  better = cand.est < best_q.est;
			default:  better = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.vld && (ctl.first || better)) begin
			best_q     <= cand;
			best_idx_q <= cand_idx;
		end
	end

	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule

`default_nettype wire

// ----- rtl/core/rts_reest.sv -----
`default_nettype none

module rts_reest import rts_pkg::*; (
	input  wire logic [ALPHA_W-1:0] alpha,
	input  wire logic [STEPS_W-1:0] steps,
	input  wire logic [EST_W-1:0]   est,
	output logic      [EST_W-1:0]   new_est
);

	localparam int SUM_W = ALPHA_W + EST_W + 1;

	logic [ALPHA_W-1:0]         a_sat;
	logic [ALPHA_W-1:0]         a_inv;
	logic [ALPHA_W+STEPS_W-1:0] p_steps;
	logic [ALPHA_W+EST_W-1:0]   p_est;
	logic [SUM_W-1:0]           acc;
	logic [SUM_W-9:0]           shifted;

	always_comb begin
		// Any weight with the top bit set means at least 1.0.
		a_sat   = alpha[ALPHA_W-1] ? ALPHA_W'(256) : alpha;
		a_inv   = ALPHA_W'(256) - a_sat;
		p_steps = a_sat * steps;
		p_est   = a_inv * est;
		acc     = SUM_W'({p_steps, 8'd0}) + SUM_W'(p_est) + SUM_W'(128);
		shifted = acc[SUM_W-1:8];
		if (shifted > (SUM_W-8)'({EST_W{1'b1}})) begin
			new_est = '1;
		end else begin
			new_est = shifted[EST_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ready_table_scheduler.sv -----
`default_nettype none

// Ready-table scheduler. The table lives in one single-port-read RAM and is
// kept in arrival order. Each item takes one command and gives one result.
// Enqueue, burst done and tick outside ratio mode pass through their own
// state (ST_ENQ, ST_REEST, ST_TICK) to ST_RESP. A dispatch reads the n live
// entries one per cycle to pick the winner, then moves every younger entry
// down one slot, also one per cycle. A tick in ratio mode rewrites every
// entry through the same read port. The next item is taken once the result
// sits in the output register.
module ready_table_scheduler import rts_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [ALPHA_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         command,
	input  wire logic [ID_W-1:0]    entry_id,
	input  wire logic [EST_W-1:0]   burst_estimate,
	input  wire logic [STEPS_W-1:0] steps_taken,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [ID_W-1:0]         result_id,
	output logic [EST_W-1:0]        result_estimate
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	state_t              state_q, state_d;
	logic [ID_W-1:0]     eid_q;
	logic [EST_W-1:0]    est_in_q;
	logic [STEPS_W-1:0]  steps_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       ptr_m1;
	logic                pend_s1;
	logic [IW-1:0]       pend_addr_s1;
	logic [ID_W-1:0]     run_id_q;
	logic [EST_W-1:0]    run_est_q;
	logic [1:0]          policy_q;
	logic [ALPHA_W-1:0]  alpha_q;
	status_t             res_status_q;
	logic [ID_W-1:0]     res_id_q;
	logic [EST_W-1:0]    res_est_q;
	logic                out_valid_q;
	logic [2:0]          status_q;
	logic [ID_W-1:0]     result_id_q;
	logic [EST_W-1:0]    result_est_q;

	logic                ram_we, ram_re;
	logic [IW-1:0]       ram_waddr, ram_raddr;
	entry_t              ram_wdata, ram_rdata;
	scan_ctl_t           scan_ctl;
	entry_t              best;
	logic [IW-1:0]       best_idx;
	logic [EST_W-1:0]    new_est;
	logic                in_acc;
	logic                out_load;
	logic                rd_more;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == ST_RESP) && (!out_valid_q || out_ready);
	assign ptr_m1   = ptr_q - CW'(1);
	assign rd_more  = ptr_q < count_q;

	rts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rts_scan #(
		.IW (IW)
	) u_scan (
		.clk      (clk),
		.ctl      (scan_ctl),
		.policy   (policy_q),
		.cand_idx (ptr_m1[IW-1:0]),
		.cand     (ram_rdata),
		.best     (best),
		.best_idx (best_idx)
	);

	rts_reest u_reest (
		.alpha   (alpha_q),
		.steps   (steps_q),
		.est     (run_est_q),
		.new_est (new_est)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (cmd_t'(command))
						CMD_ENQ:  state_d = ST_ENQ;
						CMD_DISP: state_d = ST_DISP;
						CMD_TICK: state_d = ST_TICK;
						default:  state_d = ST_REEST;
					endcase
				end
			end
			ST_ENQ:   state_d = ST_RESP;
			ST_DISP:  state_d = (count_q == '0) ? ST_RESP : ST_SCAN;
			ST_SCAN:  state_d = (ptr_q == count_q) ? ST_PICK : ST_SCAN;
			ST_PICK:  state_d = ST_SHIFT;
			ST_SHIFT: state_d = rd_more ? ST_SHIFT : ST_RESP;
			ST_TICK:  state_d = (policy_q == POL_HRRN) ? ST_AGE : ST_RESP;
			ST_AGE:   state_d = rd_more ? ST_AGE : ST_RESP;
			ST_REEST: state_d = ST_RESP;
			ST_RESP:  state_d = out_load ? ST_IDLE : ST_RESP;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_re         = 1'b0;
		ram_raddr      = ptr_q[IW-1:0];
		ram_we         = 1'b0;
		ram_waddr      = pend_addr_s1;
		ram_wdata      = ram_rdata;
		scan_ctl.vld   = 1'b0;
		scan_ctl.first = 1'b0;
		case (state_q)
			ST_ENQ: begin
				ram_we         = count_q < DEPTH_C;
				ram_waddr      = count_q[IW-1:0];
				ram_wdata.id   = eid_q;
				ram_wdata.age  = '0;
				ram_wdata.est  = est_in_q;
			end
			ST_SCAN: begin
				ram_re         = rd_more;
				scan_ctl.vld   = ptr_q != '0;
				scan_ctl.first = ptr_q == CW'(1);
			end
			ST_SHIFT: begin
				ram_re = rd_more;
				ram_we = pend_s1;
			end
			ST_AGE: begin
				ram_re = rd_more;
				ram_we = pend_s1;
				if (ram_rdata.age != AGE_MAX) begin
					ram_wdata.age = ram_rdata.age + AGE_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			pend_s1     <= 1'b0;
			run_id_q    <= '0;
			run_est_q   <= '0;
			policy_q    <= POL_FIFO;
			alpha_q     <= ALPHA_W'(128);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_POLICY: policy_q <= cfg_wdata[1:0];
					CFG_ALPHA:  alpha_q  <= cfg_wdata;
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					ptr_q   <= '0;
					pend_s1 <= 1'b0;
				end
				ST_ENQ: begin
					if (count_q < DEPTH_C) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_SCAN: ptr_q <= ptr_q + CW'(1);
				ST_PICK: begin
					ptr_q     <= CW'(best_idx) + CW'(1);
					pend_s1   <= 1'b0;
					run_id_q  <= best.id;
					run_est_q <= best.est;
				end
				ST_SHIFT, ST_AGE: begin
					pend_s1 <= ram_re;
					if (ram_re) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (state_q == ST_SHIFT && !rd_more) begin
						count_q <= count_q - CW'(1);
					end
				end
				ST_REEST: run_est_q <= new_est;
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			eid_q    <= entry_id;
			est_in_q <= burst_estimate;
			steps_q  <= steps_taken;
		end
		if (state_q == ST_SHIFT || state_q == ST_AGE) begin
			// Compaction moves an entry one slot down; aging writes it in place.
			pend_addr_s1 <= (state_q == ST_SHIFT) ? ptr_m1[IW-1:0] : ptr_q[IW-1:0];
		end
		case (state_q)
			ST_ENQ: begin
				if (count_q < DEPTH_C) begin
					res_status_q <= STS_ENQUEUED;
					res_id_q     <= eid_q;
					res_est_q    <= est_in_q;
				end else begin
					res_status_q <= STS_FULL;
					res_id_q     <= '0;
					res_est_q    <= '0;
				end
			end
			ST_DISP: begin
				res_status_q <= STS_EMPTY;
				res_id_q     <= '0;
				res_est_q    <= '0;
			end
			ST_PICK: begin
				res_status_q <= STS_DISPATCHED;
				res_id_q     <= best.id;
				res_est_q    <= best.est;
			end
			ST_TICK: begin
				res_status_q <= STS_TICKED;
				res_id_q     <= '0;
				res_est_q    <= '0;
			end
			ST_REEST: begin
				res_status_q <= STS_REESTIM;
				res_id_q     <= run_id_q;
				res_est_q    <= new_est;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			status_q     <= res_status_q;
			result_id_q  <= res_id_q;
			result_est_q <= res_est_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign result_id       = result_id_q;
	assign result_estimate = result_est_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count exceeds table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != ST_ENQ) |-> (CW'(ram_waddr) < count_q))
		else $error("table write outside live entries");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && !rd_more) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("dispatch did not remove exactly one entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("table written while idle");

endmodule

`default_nettype wire

// ----- sim/rts_result_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels and the register port of the scheduler, keeps its own
// copy of the ready table and compares every result with the oldest prediction.
module rts_result_checker import rts_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [ALPHA_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [1:0]         command,
	input  wire logic [ID_W-1:0]    entry_id,
	input  wire logic [EST_W-1:0]   burst_estimate,
	input  wire logic [STEPS_W-1:0] steps_taken,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [2:0]         status,
	input  wire logic [ID_W-1:0]    result_id,
	input  wire logic [EST_W-1:0]   result_estimate,
	output int                      fail_count,
	output int                      outstanding
);

	typedef struct packed {
		status_t          st;
		logic [ID_W-1:0]  id;
		logic [EST_W-1:0] est;
	} sched_result_t;

	logic [ID_W-1:0]    tbl_id   [DEPTH];
	logic [AGE_W-1:0]   tbl_wait [DEPTH];
	logic [EST_W-1:0]   tbl_est  [DEPTH];
	int                 live;
	logic [ID_W-1:0]    run_id;
	logic [EST_W-1:0]   run_est;
	logic [1:0]         policy;
	logic [ALPHA_W-1:0] alpha;
	sched_result_t      pending_results[$];
	int                 errors;

	function automatic int choose_slot();
		int best;
		logic [AGE_W+EST_W-1:0] lhs, rhs;
		best = 0;
		for (int i = 1; i < live; i++) begin
			if (policy == POL_HRRN) begin
				// Response ratios are ordered by cross products, so no division.
				lhs = tbl_wait[i] * tbl_est[best];
				rhs = tbl_wait[best] * tbl_est[i];
				if (lhs > rhs)
					best = i;
			end else if (policy == POL_SJF) begin
				if (tbl_est[i] < tbl_est[best])
					best = i;
			end
		end
		return best;
	endfunction

	function automatic sched_result_t run_command(cmd_t c, logic [ID_W-1:0] id,
			logic [EST_W-1:0] est, logic [STEPS_W-1:0] steps);
		sched_result_t r;
		int k;
		logic [63:0] a, acc;
		r.st = STS_TICKED;
		r.id = '0;
		r.est = '0;
		case (c)
			CMD_ENQ: begin
				if (live >= DEPTH) begin
					r.st = STS_FULL;
				end else begin
					tbl_id[live] = id;
					tbl_wait[live] = '0;
					tbl_est[live] = est;
					live++;
					r.st = STS_ENQUEUED;
					r.id = id;
					r.est = est;
				end
			end
			CMD_DISP: begin
				if (live == 0) begin
					r.st = STS_EMPTY;
				end else begin
					k = choose_slot();
					run_id = tbl_id[k];
					run_est = tbl_est[k];
					for (int i = k; i + 1 < live; i++) begin
						tbl_id[i] = tbl_id[i+1];
						tbl_wait[i] = tbl_wait[i+1];
						tbl_est[i] = tbl_est[i+1];
					end
					live--;
					r.st = STS_DISPATCHED;
					r.id = run_id;
					r.est = run_est;
				end
			end
			CMD_TICK: begin
				if (policy == POL_HRRN) begin
					for (int i = 0; i < live; i++)
						if (tbl_wait[i] != AGE_MAX)
							tbl_wait[i] = tbl_wait[i] + 1'b1;
				end
				r.st = STS_TICKED;
			end
			default: begin
				a = (alpha > 9'd256) ? 64'd256 : 64'(alpha);
				acc = a * (64'(steps) << 8) + (64'd256 - a) * 64'(run_est) + 64'd128;
				acc = acc >> 8;
				run_est = (acc > 64'hFFFFFF) ? '1 : acc[EST_W-1:0];
				r.st = STS_REESTIM;
				r.id = run_id;
				r.est = run_est;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : observe
		sched_result_t want;
		if (!arst_n) begin
			live = 0;
			run_id = '0;
			run_est = '0;
			policy = POL_FIFO;
			alpha = 9'd128;
			pending_results.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_POLICY)
					policy = cfg_wdata[1:0];
				else
					alpha = cfg_wdata;
			end
			// Results are checked before the new item is predicted, so an
			// extra result can never be matched against an item of this edge.
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing expected: status %0d id %0d estimate %0h",
						status, result_id, result_estimate);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						errors++;
					end
					if (result_id !== want.id) begin
						$error("result_id: expected %0d, got %0d", want.id, result_id);
						errors++;
					end
					if (result_estimate !== want.est) begin
						$error("result_estimate: expected %06h, got %06h",
							want.est, result_estimate);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(run_command(cmd_t'(command), entry_id,
					burst_estimate, steps_taken));
			fail_count <= errors;
			outstanding <= pending_results.size();
		end
	end

endmodule

// ----- sim/tb_ready_table_scheduler.sv -----
`timescale 1ns / 100ps

module tb_ready_table_scheduler;
	import rts_pkg::*;

	localparam int DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int SEGMENTS = 16;
	localparam int SEGMENT_ITEMS = 65;
	localparam logic [1:0] POL_SPARE = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = CFG_POLICY;
	logic [ALPHA_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         command = CMD_ENQ;
	logic [ID_W-1:0]    entry_id = '0;
	logic [EST_W-1:0]   burst_estimate = '0;
	logic [STEPS_W-1:0] steps_taken = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic [ID_W-1:0]    result_id;
	logic [EST_W-1:0]   result_estimate;

	int fail_count;
	int outstanding;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int occupancy = 0;
	int cmd_count[4] = '{0, 0, 0, 0};

	always #5 clk = ~clk;

	ready_table_scheduler #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .entry_id(entry_id),
		.burst_estimate(burst_estimate), .steps_taken(steps_taken),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_id(result_id), .result_estimate(result_estimate)
	);

	rts_result_checker #(.DEPTH(DEPTH)) results_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .entry_id(entry_id),
		.burst_estimate(burst_estimate), .steps_taken(steps_taken),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_id(result_id), .result_estimate(result_estimate),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	// A long hold-off, when requested, overrides the random stalls.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_ready_table_scheduler: errors");
		$finish;
	end

	task automatic send(cmd_t c, logic [ID_W-1:0] id, logic [EST_W-1:0] est,
			logic [STEPS_W-1:0] steps);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		entry_id <= id;
		burst_estimate <= est;
		steps_taken <= steps;
		do @(posedge clk); while (!in_ready);
		cmd_count[c]++;
		if (c == CMD_ENQ && occupancy < DEPTH)
			occupancy++;
		else if (c == CMD_DISP && occupancy > 0)
			occupancy--;
	endtask

	// Stops offering items until every predicted result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(logic [1:0] pol, logic [ALPHA_W-1:0] alpha_w);
		cfg_we <= 1'b1;
		cfg_index <= CFG_POLICY;
		cfg_wdata <= ALPHA_W'(pol);
		@(posedge clk);
		cfg_index <= CFG_ALPHA;
		cfg_wdata <= alpha_w;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item(bit filling);
		int r;
		cmd_t c;
		logic [EST_W-1:0] est;
		r = $urandom_range(99);
		if (filling)
			c = (r < 55) ? CMD_ENQ : (r < 75) ? CMD_DISP : (r < 90) ? CMD_TICK : CMD_DONE;
		else
			c = (r < 20) ? CMD_ENQ : (r < 65) ? CMD_DISP : (r < 85) ? CMD_TICK : CMD_DONE;
		// Tiny estimates make ties common under both ordering policies.
		case ($urandom_range(2))
			0: est = EST_W'($urandom_range(7));
			1: est = EST_W'($urandom_range(16'hFFFF));
			default: est = EST_W'($urandom());
		endcase
		send(c, ID_W'($urandom_range(255)), est, STEPS_W'($urandom()));
	endtask

	initial begin : stimulus
		logic [EST_W-1:0] est;
		logic [ALPHA_W-1:0] alpha_w;
		bit filling;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_mode(POL_FIFO, 9'd128);

		// Empty table, and a re-estimate of the entry left by reset.
		send(CMD_DISP, '0, '0, '0);
		send(CMD_DONE, '0, '0, '1);
		for (int i = 0; i < DEPTH; i++) begin
			case (i)
				0: est = '1;
				5: est = '0;
				9: est = 24'd1;
				default: est = EST_W'(i) * 24'h050301 + 24'h100;
			endcase
			send(CMD_ENQ, ID_W'(i * 17), est, '0);
		end
		send(CMD_ENQ, 8'hAA, 24'h123456, '0);
		send(CMD_DISP, '0, '0, '0);

		// After one tick the zero estimate has an unbounded response ratio.
		settle();
		set_mode(POL_HRRN, 9'd128);
		send(CMD_TICK, '0, '0, '0);
		send(CMD_DISP, '0, '0, '0);
		settle();
		set_mode(POL_SJF, 9'd128);
		send(CMD_DISP, '0, '0, '0);
		settle();
		set_mode(POL_SPARE, 9'd128);
		send(CMD_DISP, '0, '0, '0);
		send(CMD_TICK, '0, '0, '0);
		settle();
		set_mode(POL_SPARE, 9'd0);
		send(CMD_DONE, '0, '0, 16'h1234);
		settle();
		set_mode(POL_SPARE, 9'd256);
		send(CMD_DONE, '0, '0, '1);
		settle();
		set_mode(POL_SPARE, '1);
		send(CMD_DONE, '0, '0, 16'h0001);
		while (occupancy > 0)
			send(CMD_DISP, '0, '0, '0);

		// Age one entry a few times; a newer entry aged once must then lose to it.
		settle();
		set_mode(POL_HRRN, 9'd128);
		send(CMD_ENQ, 8'h3C, 24'd1, '0);
		repeat (3) send(CMD_TICK, '0, '0, '0);
		send(CMD_ENQ, 8'hC3, 24'd1, '0);
		send(CMD_TICK, '0, '0, '0);
		send(CMD_DISP, '0, '0, '0);
		send(CMD_DISP, '0, '0, '0);

		filling = 1'b1;
		for (int s = 0; s < SEGMENTS; s++) begin
			settle();
			case (s / 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			case ($urandom_range(3))
				0: alpha_w = '0;
				1: alpha_w = 9'd256;
				2: alpha_w = '1;
				default: alpha_w = ALPHA_W'($urandom_range(511));
			endcase
			// Every handshake phase sees all four policy codes.
			set_mode(2'((s + s / 4) % 4), alpha_w);
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				if (s == 2 && n == 20)
					hold_request = 300;
				if (s == 6 && n == 30)
					settle();
				if (occupancy == DEPTH && $urandom_range(3) == 0)
					filling = 1'b0;
				else if (occupancy == 0 && $urandom_range(3) == 0)
					filling = 1'b1;
				random_item(filling);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d enqueues, %0d dispatches, %0d ticks and %0d re-estimates,",
			cmd_count[CMD_ENQ], cmd_count[CMD_DISP], cmd_count[CMD_TICK], cmd_count[CMD_DONE]);
		$display("over all four policy codes, alpha 0 to 511, full and empty tables.");
		if (fail_count == 0 && outstanding == 0)
			$display("tb_ready_table_scheduler: clean");
		else
			$display("tb_ready_table_scheduler: errors");
		$finish;
	end

endmodule
